// ===== hdl/mbe_pkg.sv =====
`timescale 1ns / 1ps

package mbe_pkg;

    localparam int FRAC_BITS_DEFAULT = 24;
    localparam int COORD_W = 32;
    localparam int Z_W = COORD_W + 1;
    localparam int CNT_W = 10;
    localparam logic [CNT_W-1:0] MAX_ITER_RESET = CNT_W'(80);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_SQUARE,
        ST_DONE
    } mbe_state_t;

    typedef struct packed {
        logic load;
        logic update;
        logic square;
    } mbe_cmd_t;

    typedef struct packed {
        logic cont;
    } mbe_status_t;

endpackage

// ===== hdl/mbe_ctrl.sv =====
`timescale 1ns / 1ps

module mbe_ctrl
    import mbe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  mbe_status_t status,
    output mbe_cmd_t    cmd,
    output logic        busy,
    output logic        done
);

    mbe_state_t state_reg;
    mbe_state_t state_next;
    logic       accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                state_next = status.cont ? ST_SQUARE : ST_DONE;
            end
            ST_SQUARE:
            begin
                state_next = ST_UPDATE;
            end
            ST_DONE:
            begin
                state_next = start ? ST_UPDATE : ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result cycle also takes the next point
    always_comb
    begin
        busy       = 1'b0;
        done       = 1'b0;
        cmd.update = 1'b0;
        cmd.square = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
            end
            ST_UPDATE:
            begin
                busy       = 1'b1;
                cmd.update = status.cont;
            end
            ST_SQUARE:
            begin
                busy       = 1'b1;
                cmd.square = 1'b1;
            end
            ST_DONE:
            begin
                done = 1'b1;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
        accept   = start && !busy;
        cmd.load = accept;
    end

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for more than one cycle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("accepted point did not start iterating");

    a_square_after_update: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update |=> cmd.square)
        else $error("z update not followed by squaring");

endmodule

// ===== hdl/mbe_datapath.sv =====
`timescale 1ns / 1ps

module mbe_datapath
    import mbe_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEFAULT
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  mbe_cmd_t                  cmd,
    input  logic signed [COORD_W-1:0] c_real,
    input  logic signed [COORD_W-1:0] c_imag,
    input  logic                      cfg_we,
    input  logic [CNT_W-1:0]          cfg_data,
    output mbe_status_t               status,
    output logic [CNT_W-1:0]          count
);

    // z stays below 2 in magnitude while iterating, so the multiplier operands are narrow
    localparam int MW = FRAC_BITS + 2;
    localparam int SQ_W = FRAC_BITS + 3;
    localparam logic [Z_W-1:0] MagLimit = Z_W'(2) << FRAC_BITS;
    localparam logic [SQ_W-1:0] EscLevel = SQ_W'(1) << (FRAC_BITS + 2);

    logic [CNT_W-1:0]          max_reg;
    logic [CNT_W-1:0]          n_reg;
    logic signed [COORD_W-1:0] cr_reg;
    logic signed [COORD_W-1:0] ci_reg;
    logic signed [Z_W-1:0]     x_reg;
    logic signed [Z_W-1:0]     y_reg;
    logic [SQ_W-1:0]           x2_reg;
    logic [SQ_W-1:0]           y2_reg;
    logic signed [2*MW-1:0]    prod_reg;

    logic signed [Z_W-1:0]     x_next;
    logic signed [Z_W-1:0]     y_next;
    logic [SQ_W-1:0]           x2_next;
    logic [SQ_W-1:0]           y2_next;
    logic signed [2*MW-1:0]    prod_next;

    logic signed [2*MW:0]      prod2;
    logic signed [2*MW:0]      prod_sh;
    logic signed [Z_W-1:0]     x2_ext;
    logic signed [Z_W-1:0]     y2_ext;
    logic signed [Z_W-1:0]     cr_ext;
    logic signed [Z_W-1:0]     ci_ext;
    logic [Z_W-1:0]            xu;
    logic [Z_W-1:0]            yu;
    logic [Z_W-1:0]            xm;
    logic [Z_W-1:0]            ym;
    logic                      x_big;
    logic                      y_big;
    logic [MW-2:0]             xl;
    logic [MW-2:0]             yl;
    logic [2*MW-3:0]           xsq;
    logic [2*MW-3:0]           ysq;
    logic signed [MW-1:0]      xo;
    logic signed [MW-1:0]      yo;
    logic [SQ_W:0]             mag_sum;

    // z update from the registered squares and cross product
    always_comb
    begin
        prod2   = $signed({prod_reg, 1'b0});
        prod_sh = prod2 >>> FRAC_BITS;
        x2_ext  = $signed({{(Z_W-SQ_W){1'b0}}, x2_reg});
        y2_ext  = $signed({{(Z_W-SQ_W){1'b0}}, y2_reg});
        cr_ext  = $signed({cr_reg[COORD_W-1], cr_reg});
        ci_ext  = $signed({ci_reg[COORD_W-1], ci_reg});
        y_next  = Z_W'(prod_sh) + ci_ext;
        x_next  = x2_ext - y2_ext + cr_ext;
    end

    // squares saturate once |z| component reaches 2, which forces escape
    always_comb
    begin
        xu      = x_reg;
        yu      = y_reg;
        xm      = x_reg[Z_W-1] ? (Z_W'(0) - xu) : xu;
        ym      = y_reg[Z_W-1] ? (Z_W'(0) - yu) : yu;
        x_big   = xm >= MagLimit;
        y_big   = ym >= MagLimit;
        xl      = xm[MW-2:0];
        yl      = ym[MW-2:0];
        xsq     = xl * xl;
        ysq     = yl * yl;
        x2_next = x_big ? EscLevel : SQ_W'(xsq >> FRAC_BITS);
        y2_next = y_big ? EscLevel : SQ_W'(ysq >> FRAC_BITS);
        // cross product only matters when neither square saturated
        xo        = x_reg[MW-1:0];
        yo        = y_reg[MW-1:0];
        prod_next = xo * yo;
    end

    always_comb
    begin
        mag_sum     = {1'b0, x2_reg} + {1'b0, y2_reg};
        status.cont = (mag_sum < {1'b0, EscLevel}) && (n_reg < max_reg);
    end

    assign count = n_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg  <= MAX_ITER_RESET;
            n_reg    <= '0;
            x2_reg   <= '0;
            y2_reg   <= '0;
            prod_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                max_reg <= cfg_data;
            end
            if (cmd.load)
            begin
                n_reg    <= '0;
                x2_reg   <= '0;
                y2_reg   <= '0;
                prod_reg <= '0;
            end
            else if (cmd.square)
            begin
                n_reg    <= n_reg + CNT_W'(1);
                x2_reg   <= x2_next;
                y2_reg   <= y2_next;
                prod_reg <= prod_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cr_reg <= c_real;
            ci_reg <= c_imag;
        end
        if (cmd.update)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
        end
    end

    a_square_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (x2_reg <= EscLevel) && (y2_reg <= EscLevel))
        else $error("scaled square above escape level");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.square && !cmd.load) |=> (n_reg == $past(n_reg) + CNT_W'(1)))
        else $error("iteration count did not advance by one");

    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update |-> (n_reg < max_reg))
        else $error("iteration past the limit");

endmodule

// ===== hdl/mandelbrot_escape_time.sv =====
`timescale 1ns / 1ps

// channel   ports                              handshake
// point     c_real, c_imag                     taken when start && !busy
// result    iteration_count                    valid for the one cycle done is high
// config    cfg_data (max_iterations)          written when cfg_valid && cfg_ready
//
// each iteration is a z update state, then a state for the squaring multipliers
// a point with count n alternates update and square n times, then a final update
// moves to done; the done cycle may accept the next point, none while busy
// reset sets max_iterations to 80 and returns the controller to idle
// the receiver cannot stall; cfg_ready is always high

module mandelbrot_escape_time
    import mbe_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEFAULT
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic signed [COORD_W-1:0] c_real,
    input  logic signed [COORD_W-1:0] c_imag,
    output logic                      done,
    output logic [CNT_W-1:0]          iteration_count,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CNT_W-1:0]          cfg_data
);

    mbe_cmd_t    cmd;
    mbe_status_t status;

    assign cfg_ready = 1'b1;

    mbe_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    mbe_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .c_real   (c_real),
        .c_imag   (c_imag),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .status   (status),
        .count    (iteration_count)
    );

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import mbe_pkg::*;

    localparam int FRAC = FRAC_BITS_DEFAULT;
    localparam int ONE = 1 << FRAC;
    localparam longint ESCAPE_LEVEL = longint'(4) << FRAC;
    localparam longint MAG_LIMIT = longint'(2) << FRAC;
    localparam int CYCLE_LIMIT = 20_000_000;
    localparam int RANDOM_POINTS = 1500;

    // holds the iteration limit as last written and the counts still owed by the block
    class escape_scoreboard;
        logic [CNT_W-1:0] limit;
        logic [CNT_W-1:0] owed_counts[$];
        int errors;

        function new();
            limit = MAX_ITER_RESET;
            errors = 0;
        endfunction

        function void set_limit(input logic [CNT_W-1:0] value);
            limit = value;
        endfunction

        function longint square_sat(input longint v);
            longint mag;
            mag = (v < 0) ? -v : v;
            if (mag >= MAG_LIMIT)
                return ESCAPE_LEVEL;
            return (mag * mag) >>> FRAC;
        endfunction

        function logic [CNT_W-1:0] escape_count(input logic signed [COORD_W-1:0] cr,
                                                input logic signed [COORD_W-1:0] ci);
            longint x;
            longint y;
            longint x2;
            longint y2;
            int n;
            x = 0;
            y = 0;
            x2 = 0;
            y2 = 0;
            n = 0;
            while (x2 + y2 < ESCAPE_LEVEL && n < int'(limit))
            begin
                y = (((x + x) * y) >>> FRAC) + longint'(ci);
                x = x2 - y2 + longint'(cr);
                x2 = square_sat(x);
                y2 = square_sat(y);
                n++;
            end
            return CNT_W'(n);
        endfunction

        function void note_point(input logic signed [COORD_W-1:0] cr,
                                 input logic signed [COORD_W-1:0] ci);
            owed_counts.push_back(escape_count(cr, ci));
        endfunction

        function void check_count(input logic [CNT_W-1:0] got);
            logic [CNT_W-1:0] want;
            if (owed_counts.size() == 0)
            begin
                $error("iteration_count: expected none, actual %0d", got);
                errors++;
                return;
            end
            want = owed_counts.pop_front();
            if (got !== want)
            begin
                $error("iteration_count: expected %0d, actual %0d", want, got);
                errors++;
            end
        endfunction

        function int pending();
            return owed_counts.size();
        endfunction
    endclass

    logic                      clk;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic signed [COORD_W-1:0] c_real;
    logic signed [COORD_W-1:0] c_imag;
    logic                      done;
    logic [CNT_W-1:0]          iteration_count;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CNT_W-1:0]          cfg_data;

    escape_scoreboard sb;
    int burst_left;
    int random_sent;
    int watchdog_cycles;

    mandelbrot_escape_time #(
        .FRAC_BITS(FRAC)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .c_real(c_real),
        .c_imag(c_imag),
        .done(done),
        .iteration_count(iteration_count),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        watchdog_cycles = 0;
        while (watchdog_cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            watchdog_cycles++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_count(iteration_count);
    end

    // bursts of back-to-back points, then a gap that is mostly short and now and then long
    function automatic int next_gap();
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        burst_left = $urandom_range(0, 24);
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(20, 80);
        return $urandom_range(1, 8);
    endfunction

    task automatic send_point(input logic signed [COORD_W-1:0] cr,
                              input logic signed [COORD_W-1:0] ci);
        int gap;
        gap = next_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        c_real <= cr;
        c_imag <= ci;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_point(cr, ci);
    endtask

    task automatic send_random_point();
        int pick;
        int cr;
        int ci;
        pick = $urandom_range(0, 99);
        // mostly the interesting window, -2..0.5 by -1.25..1.25
        cr = int'($urandom_range(0, 5 << (FRAC - 1))) - (2 << FRAC);
        ci = int'($urandom_range(0, 5 << (FRAC - 1))) - (5 << (FRAC - 2));
        if (pick < 8)
        begin
            cr = $urandom;
            ci = $urandom;
        end
        else if (pick < 12)
        begin
            cr = $urandom;
        end
        else if (pick < 16)
        begin
            ci = $urandom;
        end
        else if (pick < 24)
        begin
            // hug the real-axis points at magnitude MAG_LIMIT where the square saturates
            cr = ($urandom_range(0, 1) ? (2 << FRAC) : -(2 << FRAC))
                 + int'($urandom_range(0, 512)) - 256;
            ci = int'($urandom_range(0, 512)) - 256;
        end
        send_point(cr, ci);
        random_sent++;
    endtask

    task automatic write_limit(input logic [CNT_W-1:0] value);
        start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        sb.set_limit(value);
    endtask

    initial
    begin
        int phase_pick;
        int phase_len;
        logic [CNT_W-1:0] phase_limit;

        sb = new();
        burst_left = 0;
        random_sent = 0;
        rst_n = 1'b0;
        start = 1'b0;
        c_real = '0;
        c_imag = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed points under the reset limit
        send_point(0, 0);
        send_point(ONE / 4, 0);
        send_point(ONE / 4 + 1024, 0);
        send_point(-ONE, 0);
        send_point(-(3 * ONE) / 2, 0);
        send_point(-2 * ONE, 0);
        send_point(-2 * ONE + 1, 0);
        send_point(2 * ONE, 0);
        send_point(0, 2 * ONE);
        send_point(0, -2 * ONE);
        send_point(0, ONE);
        send_point(-(3 * ONE) / 4, ONE / 16);
        send_point(ONE / 2, ONE / 2);
        send_point(ONE, ONE);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_point(32'h8000_0000, 32'h8000_0000);
        send_point(32'h7FFF_FFFF, 32'h8000_0000);
        send_point(32'h8000_0000, 32'h7FFF_FFFF);
        send_point(32'hFFFF_FFFF, 32'h0000_0001);
        send_point(1, -1);

        // zero limit runs no iteration at all
        write_limit(CNT_W'(0));
        repeat (15) send_random_point();
        send_point(0, 0);

        write_limit(CNT_W'(1));
        repeat (15) send_random_point();
        send_point(0, 0);

        write_limit(CNT_W'(1023));
        send_point(0, 0);
        send_point(-ONE, 0);
        send_point(ONE / 4 + 1024, 0);
        repeat (20) send_random_point();

        while (random_sent < RANDOM_POINTS)
        begin
            phase_pick = $urandom_range(0, 15);
            phase_len = $urandom_range(40, 160);
            if (phase_pick == 0)
            begin
                phase_limit = CNT_W'(1023);
                phase_len = $urandom_range(10, 25);
            end
            else if (phase_pick == 1)
                phase_limit = CNT_W'(0);
            else if (phase_pick == 2)
                phase_limit = CNT_W'(1);
            else
                phase_limit = CNT_W'($urandom_range(2, 255));
            write_limit(phase_limit);
            repeat (phase_len) send_random_point();
        end

        start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (64) @(posedge clk);
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
